// ===== design/osc_message_first_arg_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// OSC first-argument parser assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef OSC_MESSAGE_FIRST_ARG_PARSER_TOP_DEFINES_SVH
`define OSC_MESSAGE_FIRST_ARG_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define OSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/osc_mfap_pkg.sv =====
// ----------------------------------------------------------------------------
// OSC first-argument parser package
// Character codes, sizes and the result record shared by the design files.
// ----------------------------------------------------------------------------
package osc_mfap_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;

  localparam int unsigned VALUE_BYTES = 4;
  localparam int unsigned ALIGN_LOG2  = 2;

  typedef enum logic [1:0] {
    VERDICT_FLOAT  = 2'd0,
    VERDICT_INT    = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_t;

  typedef enum logic {
    KIND_ADDRESS = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  address_byte;
    logic [1:0]  verdict;
    logic [31:0] value_bits;
    logic [15:0] address_length;
    logic        last_of_run;
  } res_t;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ===== design/osc_mfap_ifs.sv =====
// ----------------------------------------------------------------------------
// OSC first-argument parser stream interfaces
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface osc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface osc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  address_byte;
  logic [1:0]  verdict;
  logic [31:0] value_bits;
  logic [15:0] address_length;
  logic        last_of_run;

  modport source (output valid, output result_kind, output address_byte, output verdict,
                  output value_bits, output address_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input address_byte, input verdict,
                  input value_bits, input address_length, input last_of_run,
                  output ready);
endinterface

// ===== design/osc_message_first_arg_parser_top.sv =====
// ----------------------------------------------------------------------------
// OSC message first-argument parser
// Parses a byte stream as an OSC message, forwards the address and reports
// the first argument as float, int or a rejection at the end of each packet.
// ----------------------------------------------------------------------------
// Use:
//   pkt carries one packet byte per beat, end_of_packet on the final byte.
//   res carries results: one beat per nonzero address byte, and one verdict
//   beat (kind, float/int/reject, 32-bit value, address length) per packet.
//   last_of_run marks the final result beat caused by one input beat.
// Output: results are registered in the result queue before they reach res.
// Throughput: one input beat per cycle while pkt.ready is high; the parse state
//   updates once per accepted byte. A 4-entry result queue decouples the sides and pkt.ready
//   is high while two entries are free, so a byte that yields two results
//   (last address byte and verdict) never overflows it.
// Stall: when res is held off the queue fills and pkt.ready drops; nothing
//   is lost or repeated.
// Reset: rst (synchronous) empties the queue and returns the parser to the
//   address phase with all counts cleared.
// ----------------------------------------------------------------------------
`include "osc_message_first_arg_parser_top_defines.svh"

module osc_message_first_arg_parser_top
  import osc_mfap_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input logic     clk,
  input logic     rst,
  osc_in_if.sink  pkt,
  osc_out_if.source res
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 4);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);
  localparam int unsigned QAw = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCw = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_ADDR      = 3'd0,
    PH_PAD       = 3'd1,
    PH_TAG_FIRST = 3'd2,
    PH_TAG_REST  = 3'd3,
    PH_VALUE     = 3'd4
  } phase_t;

  phase_t          parse_phase, parse_phase_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [15:0]     address_count, address_count_next;
  logic [7:0]      type_tag, type_tag_next;
  logic [PosW-1:0] value_start, value_start_next;
  logic [31:0]     value_shift, value_shift_next;
  logic [2:0]      value_bytes_seen, value_bytes_seen_next;
  logic            reject_flag, reject_flag_next;

  logic            accept;
  logic            addr_emit;
  logic            verdict_ok;
  logic [PosW-1:0] aligned_next;
  res_t            addr_res, verd_res;

  res_t            queue [QUEUE_DEPTH];
  logic [QAw-1:0]  wr_ptr, rd_ptr;
  logic [QCw-1:0]  count;
  logic            push_a, push_v, pop;

  assign accept = pkt.valid && pkt.ready;
  assign aligned_next = {byte_position[PosW-1:ALIGN_LOG2] + 1'b1, ALIGN_LOG2'(0)};

  always_comb begin
    parse_phase_next      = parse_phase;
    byte_position_next    = byte_position;
    address_count_next    = address_count;
    type_tag_next         = type_tag;
    value_start_next      = value_start;
    value_shift_next      = value_shift;
    value_bytes_seen_next = value_bytes_seen;
    reject_flag_next      = reject_flag;
    addr_emit             = 1'b0;

    if (byte_position >= PosMax) begin
      reject_flag_next = 1'b1;
    end else if (!reject_flag) begin
      case (parse_phase)
        PH_ADDR: begin
          if (pkt.packet_byte != 8'd0) begin
            addr_emit = 1'b1;
            if (address_count != 16'hFFFF) address_count_next = address_count + 16'd1;
          end else begin
            if (address_count == 16'd0) reject_flag_next = 1'b1;
            parse_phase_next = PH_PAD;
          end
        end
        PH_PAD: begin
          if (pkt.packet_byte != 8'd0) begin
            if (pkt.packet_byte == CH_COMMA) parse_phase_next = PH_TAG_FIRST;
            else reject_flag_next = 1'b1;
          end
        end
        PH_TAG_FIRST: begin
          type_tag_next = pkt.packet_byte;
          if (pkt.packet_byte == 8'd0) begin
            value_start_next = aligned_next;
            parse_phase_next = PH_VALUE;
          end else begin
            parse_phase_next = PH_TAG_REST;
          end
        end
        PH_TAG_REST: begin
          if (pkt.packet_byte == 8'd0) begin
            value_start_next = aligned_next;
            parse_phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (byte_position >= value_start && value_bytes_seen < 3'(VALUE_BYTES)) begin
            value_shift_next      = {value_shift[23:0], pkt.packet_byte};
            value_bytes_seen_next = value_bytes_seen + 3'd1;
          end
        end
        default: reject_flag_next = 1'b1;
      endcase
    end

    if (byte_position < PosMax) byte_position_next = byte_position + 1'b1;

    verdict_ok = !reject_flag_next && parse_phase_next == PH_VALUE &&
                 value_bytes_seen_next >= 3'(VALUE_BYTES) &&
                 (type_tag_next == CH_F || type_tag_next == CH_I);

    addr_res                = '0;
    addr_res.result_kind    = KIND_ADDRESS;
    addr_res.address_byte   = pkt.packet_byte;
    addr_res.last_of_run    = !pkt.end_of_packet;

    verd_res                = '0;
    verd_res.result_kind    = KIND_VERDICT;
    verd_res.verdict        = verdict_ok ? ((type_tag_next == CH_F) ? VERDICT_FLOAT
                                                                    : VERDICT_INT)
                                         : VERDICT_REJECT;
    verd_res.value_bits     = verdict_ok ? value_shift_next : 32'd0;
    verd_res.address_length = address_count_next;
    verd_res.last_of_run    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_ADDR;
      byte_position    <= '0;
      address_count    <= '0;
      type_tag         <= '0;
      value_start      <= '0;
      value_shift      <= '0;
      value_bytes_seen <= '0;
      reject_flag      <= 1'b0;
    end else if (accept) begin
      if (pkt.end_of_packet) begin
        parse_phase      <= PH_ADDR;
        byte_position    <= '0;
        address_count    <= '0;
        type_tag         <= '0;
        value_start      <= '0;
        value_shift      <= '0;
        value_bytes_seen <= '0;
        reject_flag      <= 1'b0;
      end else begin
        parse_phase      <= parse_phase_next;
        byte_position    <= byte_position_next;
        address_count    <= address_count_next;
        type_tag         <= type_tag_next;
        value_start      <= value_start_next;
        value_shift      <= value_shift_next;
        value_bytes_seen <= value_bytes_seen_next;
        reject_flag      <= reject_flag_next;
      end
    end
  end

  // result queue
  assign push_a = accept && addr_emit;
  assign push_v = accept && pkt.end_of_packet;
  assign pop    = res.valid && res.ready;

  assign pkt.ready = count <= QCw'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_a) begin
      queue[wr_ptr] <= addr_res;
      if (push_v) queue[wr_ptr + 1'b1] <= verd_res;
    end else if (push_v) begin
      queue[wr_ptr] <= verd_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAw'(push_a) + QAw'(push_v);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + QCw'(push_a) + QCw'(push_v) - QCw'(pop);
    end
  end

  assign res.valid          = count != '0;
  assign res.result_kind    = queue[rd_ptr].result_kind;
  assign res.address_byte   = queue[rd_ptr].address_byte;
  assign res.verdict        = queue[rd_ptr].verdict;
  assign res.value_bits     = queue[rd_ptr].value_bits;
  assign res.address_length = queue[rd_ptr].address_length;
  assign res.last_of_run    = queue[rd_ptr].last_of_run;

  `OSC_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, count <= QCw'(QUEUE_DEPTH), "queue overrun")
  `OSC_ASSERT_NEXT(a_eop_result, clk, rst, accept && pkt.end_of_packet, res.valid, "verdict missing")
  `OSC_ASSERT_NOW(a_reject_zero, clk, rst, res.valid && res.result_kind == KIND_VERDICT && res.verdict == VERDICT_REJECT, res.value_bits == 32'd0, "rejected value not zero")
  `OSC_ASSERT_NOW(a_addr_nonempty, clk, rst, parse_phase != PH_ADDR, address_count != 16'd0 || reject_flag, "empty address not rejected")

endmodule
